// ===== sv/int_to_padded_decimal_text_assert.svh =====
// Assertion macros shared by the conversion block.
`ifndef INT_TO_PADDED_DECIMAL_TEXT_ASSERT_SVH
`define INT_TO_PADDED_DECIMAL_TEXT_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted.
`define ITPDT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ITPDT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define ITPDT_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define ITPDT_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== sv/itpdt_pkg.sv =====
// Types and constants of the integer to padded decimal text block.
package itpdt_pkg;

	localparam int VALUE_W    = 32;
	localparam int SET_W      = 5;
	localparam int NUM_DIGITS = 10;
	localparam int CHAR_W     = 8;

	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

	localparam logic [0:0] REG_PAD_WIDTH   = 1'b0;
	localparam logic [0:0] REG_ZERO_DIGITS = 1'b1;

	typedef logic [NUM_DIGITS-1:0][3:0] digit_vec_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
	} number_item_t;

	typedef struct packed {
		logic [CHAR_W-1:0] character;
		logic              last;
	} text_item_t;

	typedef struct packed {
		logic               start;
		logic [VALUE_W-1:0] magnitude;
	} conv_req_t;

	typedef struct packed {
		logic       done;
		digit_vec_t digits;
	} conv_status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CONV,
		S_SIZE,
		S_TOTAL,
		S_EMIT
	} seq_state_t;

endpackage

// ===== sv/itpdt_stream_if.sv =====
// Valid/ready stream channel carrying one payload item per request.
interface itpdt_stream_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== sv/itpdt_bcd_conv.sv =====
// Shift-and-add-3 binary to BCD converter, one bit per cycle.
module itpdt_bcd_conv
	import itpdt_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  conv_req_t    req,
	output conv_status_t status
);

	localparam int BCD_W = NUM_DIGITS * 4;
	localparam int CNT_W = $clog2(VALUE_W);

	logic               busy_q;
	logic               done_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [VALUE_W-1:0] bin_q;
	digit_vec_t         bcd_q;
	digit_vec_t         adj;
	logic [BCD_W-1:0]   adj_flat;

	// Every digit at five or more is corrected before the shift doubles it.
	always_comb begin
		for (int i = 0; i < NUM_DIGITS; i++) begin
			adj[i] = (bcd_q[i] >= 4'd5) ? bcd_q[i] + 4'd3 : bcd_q[i];
		end
	end
	assign adj_flat = adj;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(VALUE_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			bin_q <= req.magnitude;
			bcd_q <= '0;
		end else if (busy_q) begin
			bin_q <= {bin_q[VALUE_W-2:0], 1'b0};
			bcd_q <= digit_vec_t'({adj_flat[BCD_W-2:0], bin_q[VALUE_W-1]});
		end
	end

	assign status.done   = done_q;
	assign status.digits = bcd_q;

endmodule

// ===== sv/itpdt_seq.sv =====
// Sequencer: takes a number, runs the converter, sizes the field and emits text.
module itpdt_seq
	import itpdt_pkg::*;
#(
	parameter int MAX_WIDTH = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [SET_W-1:0]     pad_width,
	input  logic [SET_W-1:0]     zero_digits,
	itpdt_stream_if.sink         number,
	itpdt_stream_if.source       text,
	output conv_req_t            conv_req,
	input  conv_status_t         conv_status
);

	localparam int CNT_W = $clog2(MAX_WIDTH + 2);

	seq_state_t        state_q, state_d;
	logic              neg_q;
	logic [3:0]        nd_q;
	logic [CNT_W-1:0]  ndig_q;
	logic [CNT_W-1:0]  rem_q;
	logic              text_valid_q;
	text_item_t        text_item_q;

	logic              accept;
	logic              load;
	logic              is_last;
	logic [CNT_W-1:0]  mw_c, mz_c;
	logic [3:0]        nd_c;
	logic [CNT_W-1:0]  ndig_c, body_c, total_c;
	logic [CNT_W-1:0]  rem_m1;
	logic [3:0]        digit_idx;
	logic [3:0]        digit;
	logic [CHAR_W-1:0] char_c;
	logic [VALUE_W-1:0] raw;

	assign mw_c = (32'(pad_width) > MAX_WIDTH) ? CNT_W'(MAX_WIDTH) : CNT_W'(pad_width);
	assign mz_c = (32'(zero_digits) > MAX_WIDTH) ? CNT_W'(MAX_WIDTH) : CNT_W'(zero_digits);

	// Significant digits: one past the highest nonzero digit, at least one.
	always_comb begin
		nd_c = 4'd1;
		for (int i = 0; i < NUM_DIGITS; i++) begin
			if (conv_status.digits[i] != 4'd0) begin
				nd_c = 4'(i + 1);
			end
		end
	end

	assign ndig_c  = (CNT_W'(nd_c) > mz_c) ? CNT_W'(nd_c) : mz_c;
	assign body_c  = ndig_q + CNT_W'(neg_q);
	assign total_c = (body_c > mw_c) ? body_c : mw_c;

	// The character is chosen by its distance from the right end of the field.
	assign rem_m1    = rem_q - CNT_W'(1);
	assign digit_idx = rem_m1[3:0];
	always_comb begin
		digit = 4'd0;
		for (int i = 0; i < NUM_DIGITS; i++) begin
			if (digit_idx == 4'(i)) begin
				digit = conv_status.digits[i];
			end
		end
	end

	always_comb begin
		if (rem_q <= CNT_W'(nd_q)) begin
			char_c = CHAR_ZERO + CHAR_W'(digit);
		end else if (rem_q <= ndig_q) begin
			char_c = CHAR_ZERO;
		end else if (neg_q && (rem_q == ndig_q + CNT_W'(1))) begin
			char_c = CHAR_MINUS;
		end else begin
			char_c = CHAR_SPACE;
		end
	end

	assign is_last = (rem_q == CNT_W'(1));
	assign raw     = number.payload.value;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (number.valid) begin
					state_d = S_CONV;
				end
			end
			S_CONV: begin
				if (conv_status.done) begin
					state_d = S_SIZE;
				end
			end
			S_SIZE:  state_d = S_TOTAL;
			S_TOTAL: state_d = S_EMIT;
			S_EMIT: begin
				if (load && is_last) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		number.ready = 1'b0;
		load         = 1'b0;
		unique case (state_q)
			S_IDLE:  number.ready = 1'b1;
			S_EMIT:  load = !text_valid_q || text.ready;
			default: begin
				number.ready = 1'b0;
				load         = 1'b0;
			end
		endcase
	end

	assign accept             = number.valid && number.ready;
	assign conv_req.start     = accept;
	assign conv_req.magnitude = raw[VALUE_W-1] ? (VALUE_W'(0) - raw) : raw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			text_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load) begin
				text_valid_q <= 1'b1;
			end else if (text.ready) begin
				text_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			neg_q <= raw[VALUE_W-1];
		end
		if (state_q == S_SIZE) begin
			nd_q   <= nd_c;
			ndig_q <= ndig_c;
		end
		if (state_q == S_TOTAL) begin
			rem_q <= total_c;
		end else if (load) begin
			rem_q <= rem_m1;
		end
		if (load) begin
			text_item_q.character <= char_c;
			text_item_q.last      <= is_last;
		end
	end

	assign text.valid   = text_valid_q;
	assign text.payload = text_item_q;

endmodule

// ===== sv/int_to_padded_decimal_text.sv =====
// Top level of the signed integer to right-justified decimal text converter.
// Each accepted number comes out as its decimal text, one ASCII character per
// request, left to right, with last set on the final character: leading
// spaces up to the pad width setting, a minus sign for negative values,
// leading zeros up to the zero digit setting, then the digits. Both settings
// saturate at MAX_WIDTH, so a number gives at most MAX_WIDTH + 1 characters.
// With the output never stalled, a number goes from its acceptance to the
// acceptance of the next through: the acceptance, the one-bit-per-cycle
// shift-and-add-3 loop that produces the BCD digits, the done flag of the
// loop, S_SIZE and S_TOTAL to size the field, then one character per cycle
// while the output is taken. The next number is accepted from the cycle after
// the final character has been moved into the output register. Settings are
// written through cfg_we, cfg_index and cfg_data while the block is idle; the
// user must keep to this, as the block itself does not enforce it.
`include "int_to_padded_decimal_text_assert.svh"

module int_to_padded_decimal_text
	import itpdt_pkg::*;
#(
	parameter int MAX_WIDTH = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	itpdt_stream_if.sink     number,
	itpdt_stream_if.source   text,
	input  logic             cfg_we,
	input  logic [0:0]       cfg_index,
	input  logic [SET_W-1:0] cfg_data
);

	logic [SET_W-1:0] pad_width_q;
	logic [SET_W-1:0] zero_digits_q;
	conv_req_t        conv_req;
	conv_status_t     conv_status;
	logic             number_accept;
	logic             char_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pad_width_q   <= '0;
			zero_digits_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PAD_WIDTH:   pad_width_q   <= cfg_data;
				REG_ZERO_DIGITS: zero_digits_q <= cfg_data;
				default: ;
			endcase
		end
	end

	itpdt_bcd_conv u_conv (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (conv_req),
		.status (conv_status)
	);

	itpdt_seq #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.pad_width   (pad_width_q),
		.zero_digits (zero_digits_q),
		.number      (number),
		.text        (text),
		.conv_req    (conv_req),
		.conv_status (conv_status)
	);

	assign number_accept = number.valid && number.ready;
	assign char_ok = (text.payload.character >= CHAR_ZERO &&
		text.payload.character <= CHAR_ZERO + 8'd9) ||
		text.payload.character == CHAR_MINUS || text.payload.character == CHAR_SPACE;

	// Once a number is taken the block stays busy until its text is built.
	`ITPDT_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, number_accept, !number.ready)

	// While idle, a character still waiting at the output ends its number.
	`ITPDT_ASSERT_NOW(a_idle_holds_last, clk, arst_n, number.ready && text.valid, text.payload.last)

	// Only digits, the minus sign and the pad space are ever produced.
	`ITPDT_ASSERT_NOW(a_char_set, clk, arst_n, text.valid, char_ok)

endmodule

// ===== test/tb_int_to_padded_decimal_text.sv =====
// Testbench of the integer to padded decimal text converter: predicted text against the block.
`timescale 1ns / 100ps

module tb_int_to_padded_decimal_text;
	import itpdt_pkg::*;

	localparam int MAX_TEXT    = 16;
	localparam int STALL_LIMIT = 2000;
	localparam int END_CYCLES  = 60;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [0:0]       cfg_index;
	logic [SET_W-1:0] cfg_data;

	itpdt_stream_if #(.payload_t(number_item_t)) number_if ();
	itpdt_stream_if #(.payload_t(text_item_t))   text_if ();

	int_to_padded_decimal_text #(
		.MAX_WIDTH(MAX_TEXT)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.number   (number_if),
		.text     (text_if),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// Settings as the block holds them, and the characters still to come.
	logic [SET_W-1:0] width_setting;
	logic [SET_W-1:0] zeros_setting;
	text_item_t       expected_text[$];
	int               error_count;

	// Sender burst state.
	int burst_left;
	int gap_left;
	bit sender_live;
	bit sender_gaps_on;

	// Receiver stall pattern.
	logic [15:0] ready_mask;
	logic [5:0]  mask_cycle;

	int idle_cycles;

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch: %s got %0d (0x%02h) want %0d (0x%02h)", what, got, got, want, want);
		error_count++;
	endtask

	// Builds the text of one number under the current settings and queues it.
	function automatic void predict_text(input logic [VALUE_W-1:0] raw);
		logic              neg;
		logic [31:0]       mag;
		logic [CHAR_W-1:0] digit_chars[NUM_DIGITS];
		logic [CHAR_W-1:0] line[$];
		int                nd;
		int                ndig;
		int                body;
		int                total;
		int                mw;
		int                mz;
		text_item_t        item;
		neg = raw[VALUE_W-1];
		mag = neg ? (32'd0 - raw) : raw;
		nd = 0;
		do begin
			digit_chars[nd] = CHAR_ZERO + CHAR_W'(mag % 10);
			nd++;
			mag = mag / 10;
		end while (mag != 0);
		mw = (int'(width_setting) > MAX_TEXT) ? MAX_TEXT : int'(width_setting);
		mz = (int'(zeros_setting) > MAX_TEXT) ? MAX_TEXT : int'(zeros_setting);
		ndig = (nd > mz) ? nd : mz;
		body = ndig + (neg ? 1 : 0);
		total = (body > mw) ? body : mw;
		for (int k = body; k < total; k++)
			line.push_back(CHAR_SPACE);
		if (neg)
			line.push_back(CHAR_MINUS);
		for (int k = nd; k < ndig; k++)
			line.push_back(CHAR_ZERO);
		for (int k = nd; k > 0; k--)
			line.push_back(digit_chars[k-1]);
		foreach (line[k]) begin
			item.character = line[k];
			item.last = (k == line.size() - 1);
			expected_text.push_back(item);
		end
	endfunction

	// Offers one number and returns at the edge where it is accepted.
	task automatic send_number(input logic [VALUE_W-1:0] value);
		if (gap_left > 0) begin
			repeat (gap_left) @(posedge clk);
			gap_left = 0;
		end
		number_if.valid <= 1'b1;
		number_if.payload.value <= value;
		sender_live = 1'b1;
		do
			@(posedge clk);
		while (!number_if.ready);
		predict_text(value);
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 6);
			if (sender_gaps_on && $urandom_range(0, 2) != 0)
				gap_left = $urandom_range(1, 45);
			// With no gap the next request follows at once, so valid stays high.
			if (gap_left > 0) begin
				number_if.valid <= 1'b0;
				sender_live = 1'b0;
			end
		end
	endtask

	// Stops the sender and waits until every predicted character has come out.
	task automatic drain_text();
		if (sender_live) begin
			number_if.valid <= 1'b0;
			sender_live = 1'b0;
		end
		while (expected_text.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic apply_settings(input logic [SET_W-1:0] width, input logic [SET_W-1:0] zeros);
		cfg_we <= 1'b1;
		cfg_index <= REG_PAD_WIDTH;
		cfg_data <= width;
		@(posedge clk);
		width_setting = width;
		cfg_index <= REG_ZERO_DIGITS;
		cfg_data <= zeros;
		@(posedge clk);
		zeros_setting = zeros;
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [VALUE_W-1:0] pick_value();
		logic [31:0] p;
		logic [31:0] v;
		case ($urandom_range(0, 4))
			0: v = $urandom();
			1: v = 32'($urandom_range(0, 2000)) - 32'd1000;
			2: begin
				p = 32'd1;
				repeat ($urandom_range(0, 9)) p = p * 10;
				v = p - 32'($urandom_range(0, 1));
				if ($urandom_range(0, 1) != 0)
					v = 32'd0 - v;
			end
			3: begin
				case ($urandom_range(0, 3))
					0: v = 32'h8000_0000;
					1: v = 32'h7FFF_FFFF;
					2: v = 32'h0000_0000;
					default: v = 32'hFFFF_FFFF;
				endcase
			end
			default: v = $urandom() >> $urandom_range(0, 31);
		endcase
		return v;
	endfunction

	// Extremes of the value at reset settings, where no padding applies.
	task automatic test_plain_values();
		send_number(32'd0);
		send_number(32'd1);
		send_number(32'hFFFF_FFFF);
		send_number(32'd9);
		send_number(32'd10);
		send_number(-32'sd10);
		send_number(32'h7FFF_FFFF);
		send_number(32'h8000_0000);
		send_number(32'd1234567890);
		send_number(-32'sd999999999);
		drain_text();
	endtask

	// Spaces, zeros, settings shorter than the text and saturated settings.
	task automatic test_padding();
		apply_settings(5'd8, 5'd0);
		send_number(32'd42);
		send_number(-32'sd42);
		send_number(32'd123456789);
		drain_text();
		apply_settings(5'd0, 5'd5);
		send_number(-32'sd7);
		send_number(32'd123456);
		drain_text();
		apply_settings(5'd12, 5'd6);
		send_number(-32'sd3);
		send_number(32'd0);
		drain_text();
		apply_settings(5'd16, 5'd16);
		send_number(32'h8000_0000);
		send_number(32'd5);
		drain_text();
		apply_settings(5'd31, 5'd31);
		send_number(-32'sd5);
		send_number(32'd77);
		drain_text();
		apply_settings(5'd17, 5'd0);
		send_number(32'd1);
		drain_text();
	endtask

	task automatic test_random_values();
		logic [SET_W-1:0] width;
		logic [SET_W-1:0] zeros;
		for (int phase = 0; phase < 8; phase++) begin
			case (phase)
				0: begin width = 5'd0;  zeros = 5'd0;  end
				1: begin width = 5'd31; zeros = 5'd31; end
				2: begin width = 5'd16; zeros = 5'd0;  end
				3: begin width = 5'd0;  zeros = 5'd16; end
				default: begin
					width = SET_W'($urandom_range(0, 31));
					zeros = SET_W'($urandom_range(0, 31));
				end
			endcase
			// One phase runs back to back to keep the block busy.
			sender_gaps_on = (phase != 2);
			apply_settings(width, zeros);
			repeat (11) send_number(pick_value());
			drain_text();
		end
		sender_gaps_on = 1'b1;
	endtask

	// Receiver: ready follows a 16-bit pattern indexed by mask_cycle, redrawn whenever mask_cycle wraps to zero.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ready_mask <= '1;
			mask_cycle <= '0;
			text_if.ready <= 1'b0;
		end else begin
			mask_cycle <= mask_cycle + 1'b1;
			if (mask_cycle == '0) begin
				if ($urandom_range(0, 2) == 0)
					ready_mask <= '1;
				else
					ready_mask <= 16'($urandom()) | 16'h0001;
			end
			text_if.ready <= ready_mask[mask_cycle[3:0]];
		end
	end

	always @(posedge clk) begin : check_text
		text_item_t want;
		if (arst_n && text_if.valid && text_if.ready) begin
			if (expected_text.size() == 0) begin
				report_mismatch("character with none expected",
					int'(text_if.payload.character), 0);
			end else begin
				want = expected_text.pop_front();
				if (text_if.payload.character !== want.character)
					report_mismatch("character", int'(text_if.payload.character),
						int'(want.character));
				if (text_if.payload.last !== want.last)
					report_mismatch("last", int'(text_if.payload.last), int'(want.last));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (number_if.valid && number_if.ready) ||
			(text_if.valid && text_if.ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		number_if.valid <= 1'b0;
		number_if.payload <= '0;
		cfg_we <= 1'b0;
		cfg_index <= REG_PAD_WIDTH;
		cfg_data <= '0;
		width_setting = '0;
		zeros_setting = '0;
		error_count = 0;
		idle_cycles = 0;
		burst_left = 3;
		gap_left = 0;
		sender_live = 1'b0;
		sender_gaps_on = 1'b1;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_plain_values();
		test_padding();
		test_random_values();

		drain_text();
		repeat (END_CYCLES) @(posedge clk);
		if (expected_text.size() != 0)
			report_mismatch("characters left over", expected_text.size(), 0);
		if (error_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ===== int_to_padded_decimal_text.f =====
+incdir+sv
sv/itpdt_pkg.sv
sv/itpdt_stream_if.sv
sv/itpdt_bcd_conv.sv
sv/itpdt_seq.sv
sv/int_to_padded_decimal_text.sv
test/tb_int_to_padded_decimal_text.sv
